// File: hw/rtl/adam_pkg.sv
// shared types, constants and codes for the adam optimizer update block
package adam_pkg;

    localparam int NUM_PARAMS_DEF = 4096;
    localparam int IDX_W = 12;
    localparam int DIV_W = 64;
    localparam int SQRT_W = 64;

    localparam logic [24:0] ONE_Q24 = 25'h1000000;
    localparam logic [23:0] LR_RESET = 24'd16777;
    localparam logic [23:0] B1_RESET = 24'd15099494;
    localparam logic [23:0] B2_RESET = 24'd16760439;
    localparam logic [31:0] EPS_RESET = 32'd429;

    localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] CFG_FIRST_DECAY = 2'd1;
    localparam logic [1:0] CFG_SECOND_DECAY = 2'd2;
    localparam logic [1:0] CFG_STABILIZER = 2'd3;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM_M,
        ST_SQ,
        ST_G2,
        ST_MUL_C,
        ST_MUL_D,
        ST_SUM_V,
        ST_DIV1,
        ST_WAIT1,
        ST_DIV2,
        ST_WAIT2,
        ST_SQRT,
        ST_WAITS,
        ST_PREP3,
        ST_DIV3,
        ST_WAIT3,
        ST_FINAL
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_REDUCE,
        OP_READ,
        OP_MUL_A,
        OP_MUL_B,
        OP_SUM_M,
        OP_SQ,
        OP_G2,
        OP_MUL_C,
        OP_MUL_D,
        OP_SUM_V,
        OP_DIV1,
        OP_TAKE_M,
        OP_DIV2,
        OP_TAKE_V,
        OP_SQRT,
        OP_TAKE_R,
        OP_PREP3,
        OP_DIV3,
        OP_TAKE_S,
        OP_FINAL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic idx_ge;
        logic div_done;
        logic sqrt_done;
    } status_t;

endpackage

// File: hw/rtl/adam_optimizer_update_top.sv
// top level of the adam optimizer update block
//
//  channel   signals                                       handshake
//  ------    -------                                       ---------
//  item in   elem_index weight_in gradient end_of_step     start high, busy low
//  result    weight_out saturated                          done strobe, one cycle
//  config    cfg_we cfg_index cfg_data                     cfg_we high, no wait
//
// the next item can be accepted when the result of the previous one is taken;
// three divider passes and the square root pass set the time to the result,
// plus the index reduction steps
// after reset the moment memories are cleared, one entry a cycle, all NUM_PARAMS
// entries with busy high; config writes are taken during the sweep
// results are strobed once on done and cannot be held off
module adam_optimizer_update_top
    import adam_pkg::*;
#(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [IDX_W-1:0]   elem_index,
    input  logic signed [31:0] weight_in,
    input  logic signed [31:0] gradient,
    input  logic               end_of_step,
    output logic               done,
    output logic signed [31:0] weight_out,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    adam_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    adam_dp #(
        .NUM_PARAMS(NUM_PARAMS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .elem_index (elem_index),
        .weight_in  (weight_in),
        .gradient   (gradient),
        .end_of_step(end_of_step),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .weight_out (weight_out),
        .saturated  (saturated)
    );

endmodule

// File: hw/rtl/adam_div.sv
// iterative restoring divider, one quotient bit per cycle
module adam_div
    import adam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    localparam int CW = $clog2(DIV_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   shifted;

    always_comb
    begin
        run_next = run_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        den_next = den_reg;
        shifted = {rem_reg[DIV_W-1:0], q_reg[DIV_W-1]};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            q_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hw/rtl/adam_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module adam_sqrt
    import adam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [SQRT_W-1:0]   x,
    output logic                done,
    output logic [SQRT_W/2-1:0] root
);

    localparam int STEPS = SQRT_W / 2;
    localparam int CW = $clog2(STEPS);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SQRT_W-1:0] x_reg, x_next;
    logic [SQRT_W-1:0] res_reg, res_next;
    logic [SQRT_W-1:0] bit_reg, bit_next;
    logic [SQRT_W-1:0] trial;

    always_comb
    begin
        run_next = run_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        x_next = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial = res_reg + bit_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            x_next = x;
            res_next = '0;
            bit_next = {2'b01, {(SQRT_W - 2){1'b0}}};
        end
        else if (run_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[SQRT_W/2-1:0];

endmodule

// File: hw/rtl/adam_dp.sv
// datapath: config registers, moment memories, multipliers, divider and root units
module adam_dp
    import adam_pkg::*;
#(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [IDX_W-1:0]   elem_index,
    input  logic signed [31:0] weight_in,
    input  logic signed [31:0] gradient,
    input  logic               end_of_step,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] weight_out,
    output logic               saturated
);

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic [20:0] NP = 21'(NUM_PARAMS);
    localparam logic [IDX_W-1:0] NP_IDX = IDX_W'(NUM_PARAMS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PARAMS - 1);
    localparam logic [33:0] STEP_LIMIT = 34'h200000000;
    localparam logic [47:0] VHAT_LIMIT = 48'hFFFFFFFFFFFF;

    logic [23:0] lr_reg, b1_reg, b2_reg, p1_reg, p2_reg;
    logic [31:0] eps_reg;

    logic [31:0] mem_m [NUM_PARAMS];
    logic [31:0] mem_v [NUM_PARAMS];

    logic [AW-1:0]      clr_addr_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] w_reg, g_reg, m_rd_reg;
    logic [31:0]        v_rd_reg;
    logic               eos_reg, sat_reg, neg_reg;
    logic signed [57:0] pa_reg, pb_reg;
    logic signed [31:0] mn_reg;
    logic [65:0]        sq_reg;
    logic [31:0]        g2_reg, vn_reg, am_reg, mh_reg, root_reg;
    logic [57:0]        pc_reg, pd_reg;
    logic [47:0]        vh_reg;
    logic [48:0]        den_reg;
    logic [55:0]        prod_reg;
    logic [33:0]        mag_reg;
    logic               done_reg;
    logic signed [31:0] wout_reg;
    logic               osat_reg;

    logic [AW-1:0]      addr;
    logic [24:0]        omb1, omb2, c1, c2;
    logic signed [57:0] sum_m;
    logic signed [33:0] sh_m;
    logic signed [32:0] gx;
    logic [32:0]        ag;
    logic [66:0]        g2_full;
    logic [57:0]        sum_v;
    logic [33:0]        sh_v;
    logic [31:0]        vn_clip;
    logic               vn_ovf;
    logic               m_we, v_we, rd_en;
    logic [AW-1:0]      waddr;
    logic [31:0]        m_wdata, v_wdata;
    logic               div_go, sqrt_go, div_done, sqrt_done;
    logic [DIV_W-1:0]   div_num, div_den, quot;
    logic [SQRT_W-1:0]  sqrt_x;
    logic [SQRT_W/2-1:0] sqrt_root;
    logic [31:0]        mh_lim;
    logic signed [34:0] step;
    logic signed [35:0] wdiff;
    logic [48:0]        p1_prod, p2_prod;

    assign addr = AW'(idx_reg);
    assign omb1 = ONE_Q24 - {1'b0, b1_reg};
    assign omb2 = ONE_Q24 - {1'b0, b2_reg};
    assign c1 = ONE_Q24 - {1'b0, p1_reg};
    assign c2 = ONE_Q24 - {1'b0, p2_reg};

    assign sum_m = pa_reg + pb_reg + 58'sd8388608;
    assign sh_m = 34'(sum_m >>> 24);
    assign gx = {g_reg[31], g_reg};
    assign ag = gx[32] ? 33'(-gx) : 33'(gx);
    assign g2_full = {1'b0, sq_reg} + 67'd32768;
    assign sum_v = pc_reg + pd_reg + 58'd8388608;
    assign sh_v = sum_v[57:24];
    assign vn_ovf = (sh_v[33:32] != 2'b00);
    assign vn_clip = vn_ovf ? 32'hFFFFFFFF : sh_v[31:0];
    assign mh_lim = neg_reg ? 32'h80000000 : 32'h7FFFFFFF;
    assign step = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign wdiff = 36'(w_reg) - 36'(step);
    assign p1_prod = 49'(p1_reg * b1_reg) + 49'd8388608;
    assign p2_prod = 49'(p2_reg * b2_reg) + 49'd8388608;

    assign m_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_SUM_V);
    assign v_we = m_we;
    assign rd_en = (cmd.op == OP_READ);
    assign waddr = (cmd.op == OP_CLEAR) ? clr_addr_reg : addr;
    assign m_wdata = (cmd.op == OP_CLEAR) ? 32'd0 : mn_reg;
    assign v_wdata = (cmd.op == OP_CLEAR) ? 32'd0 : vn_clip;

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem_m[waddr] <= m_wdata;
        if (rd_en)
            m_rd_reg <= mem_m[addr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            mem_v[waddr] <= v_wdata;
        if (rd_en)
            v_rd_reg <= mem_v[addr];
    end

    always_comb
    begin
        div_go = 1'b0;
        div_num = '0;
        div_den = '0;
        sqrt_go = 1'b0;
        sqrt_x = {vh_reg, 16'd0};
        unique case (cmd.op)
            OP_DIV1:
            begin
                div_go = 1'b1;
                div_num = DIV_W'({am_reg, 24'd0}) + DIV_W'(c1 >> 1);
                div_den = DIV_W'(c1);
            end
            OP_DIV2:
            begin
                div_go = 1'b1;
                div_num = DIV_W'({vn_reg, 24'd0}) + DIV_W'(c2 >> 1);
                div_den = DIV_W'(c2);
            end
            OP_DIV3:
            begin
                div_go = 1'b1;
                div_num = DIV_W'({prod_reg, 8'd0}) + DIV_W'(den_reg >> 1);
                div_den = DIV_W'(den_reg);
            end
            OP_SQRT:
                sqrt_go = 1'b1;
            default:
            begin
            end
        endcase
    end

    adam_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (quot)
    );

    adam_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (sqrt_go),
        .x    (sqrt_x),
        .done (sqrt_done),
        .root (sqrt_root)
    );

    // config registers and running powers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
            b1_reg <= B1_RESET;
            b2_reg <= B2_RESET;
            eps_reg <= EPS_RESET;
            p1_reg <= B1_RESET;
            p2_reg <= B2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: lr_reg <= cfg_data[23:0];
                CFG_FIRST_DECAY:
                begin
                    b1_reg <= cfg_data[23:0];
                    p1_reg <= cfg_data[23:0];
                    p2_reg <= b2_reg;
                end
                CFG_SECOND_DECAY:
                begin
                    b2_reg <= cfg_data[23:0];
                    p1_reg <= b1_reg;
                    p2_reg <= cfg_data[23:0];
                end
                CFG_STABILIZER: eps_reg <= cfg_data;
            endcase
        end
        else if ((cmd.op == OP_FINAL) && eos_reg)
        begin
            p1_reg <= p1_prod[47:24];
            p2_reg <= p2_prod[47:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_FINAL);
            if (cmd.op == OP_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                idx_reg <= elem_index;
                w_reg <= weight_in;
                g_reg <= gradient;
                eos_reg <= end_of_step;
                sat_reg <= 1'b0;
            end
            OP_REDUCE:
                if (status.idx_ge)
                    idx_reg <= idx_reg - NP_IDX;
            OP_MUL_A:
                pa_reg <= 58'($signed({1'b0, b1_reg}) * m_rd_reg);
            OP_MUL_B:
                pb_reg <= 58'($signed({1'b0, omb1}) * g_reg);
            OP_SUM_M:
            begin
                if (sh_m > 34'sd2147483647)
                begin
                    mn_reg <= 32'sh7FFFFFFF;
                    sat_reg <= 1'b1;
                end
                else if (sh_m < -34'sd2147483648)
                begin
                    mn_reg <= 32'sh80000000;
                    sat_reg <= 1'b1;
                end
                else
                    mn_reg <= 32'(sh_m);
            end
            OP_SQ:
                sq_reg <= 66'(ag * ag);
            OP_G2:
            begin
                if (g2_full[66:48] != '0)
                begin
                    g2_reg <= 32'hFFFFFFFF;
                    sat_reg <= 1'b1;
                end
                else
                    g2_reg <= g2_full[47:16];
            end
            OP_MUL_C:
                pc_reg <= 58'(b2_reg * v_rd_reg);
            OP_MUL_D:
                pd_reg <= 58'(omb2 * g2_reg);
            OP_SUM_V:
            begin
                vn_reg <= vn_clip;
                if (vn_ovf)
                    sat_reg <= 1'b1;
                neg_reg <= mn_reg[31];
                am_reg <= mn_reg[31] ? 32'(-{mn_reg[31], mn_reg}) : 32'(mn_reg);
            end
            OP_TAKE_M:
            begin
                if (quot > DIV_W'(mh_lim))
                begin
                    mh_reg <= mh_lim;
                    sat_reg <= 1'b1;
                end
                else
                    mh_reg <= quot[31:0];
            end
            OP_TAKE_V:
            begin
                if (quot > DIV_W'(VHAT_LIMIT))
                begin
                    vh_reg <= VHAT_LIMIT;
                    sat_reg <= 1'b1;
                end
                else
                    vh_reg <= quot[47:0];
            end
            OP_TAKE_R:
                root_reg <= sqrt_root;
            OP_PREP3:
            begin
                den_reg <= 49'({root_reg, 16'd0}) + 49'(eps_reg);
                prod_reg <= 56'(lr_reg * mh_reg);
            end
            OP_TAKE_S:
            begin
                if (mh_reg == 32'd0)
                    mag_reg <= '0;
                else if (den_reg == '0)
                begin
                    mag_reg <= STEP_LIMIT;
                    sat_reg <= 1'b1;
                end
                else if (quot > DIV_W'(STEP_LIMIT))
                    mag_reg <= STEP_LIMIT;
                else
                    mag_reg <= quot[33:0];
            end
            OP_FINAL:
            begin
                if (wdiff > 36'sd2147483647)
                begin
                    wout_reg <= 32'sh7FFFFFFF;
                    osat_reg <= 1'b1;
                end
                else if (wdiff < -36'sd2147483648)
                begin
                    wout_reg <= 32'sh80000000;
                    osat_reg <= 1'b1;
                end
                else
                begin
                    wout_reg <= 32'(wdiff);
                    osat_reg <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.clr_last = (clr_addr_reg == LAST_ADDR);
    assign status.idx_ge = ({9'd0, idx_reg} >= NP);
    assign status.div_done = div_done;
    assign status.sqrt_done = sqrt_done;

    assign done = done_reg;
    assign weight_out = wout_reg;
    assign saturated = osat_reg;

endmodule

// File: hw/rtl/adam_ctrl.sv
// controller state machine sequencing the memory clear after reset and the datapath for one item
module adam_ctrl
    import adam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  state_next = status.clr_last ? ST_IDLE : ST_CLEAR;
            ST_IDLE:   state_next = start ? ST_REDUCE : ST_IDLE;
            ST_REDUCE: state_next = status.idx_ge ? ST_REDUCE : ST_READ;
            ST_READ:   state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_SUM_M;
            ST_SUM_M:  state_next = ST_SQ;
            ST_SQ:     state_next = ST_G2;
            ST_G2:     state_next = ST_MUL_C;
            ST_MUL_C:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_SUM_V;
            ST_SUM_V:  state_next = ST_DIV1;
            ST_DIV1:   state_next = ST_WAIT1;
            ST_WAIT1:  state_next = status.div_done ? ST_DIV2 : ST_WAIT1;
            ST_DIV2:   state_next = ST_WAIT2;
            ST_WAIT2:  state_next = status.div_done ? ST_SQRT : ST_WAIT2;
            ST_SQRT:   state_next = ST_WAITS;
            ST_WAITS:  state_next = status.sqrt_done ? ST_PREP3 : ST_WAITS;
            ST_PREP3:  state_next = ST_DIV3;
            ST_DIV3:   state_next = ST_WAIT3;
            ST_WAIT3:  state_next = status.div_done ? ST_FINAL : ST_WAIT3;
            ST_FINAL:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:  cmd.op = OP_CLEAR;
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.op = start ? OP_LOAD : OP_NONE;
            end
            ST_REDUCE: cmd.op = OP_REDUCE;
            ST_READ:   cmd.op = OP_READ;
            ST_MUL_A:  cmd.op = OP_MUL_A;
            ST_MUL_B:  cmd.op = OP_MUL_B;
            ST_SUM_M:  cmd.op = OP_SUM_M;
            ST_SQ:     cmd.op = OP_SQ;
            ST_G2:     cmd.op = OP_G2;
            ST_MUL_C:  cmd.op = OP_MUL_C;
            ST_MUL_D:  cmd.op = OP_MUL_D;
            ST_SUM_V:  cmd.op = OP_SUM_V;
            ST_DIV1:   cmd.op = OP_DIV1;
            ST_WAIT1:  cmd.op = status.div_done ? OP_TAKE_M : OP_NONE;
            ST_DIV2:   cmd.op = OP_DIV2;
            ST_WAIT2:  cmd.op = status.div_done ? OP_TAKE_V : OP_NONE;
            ST_SQRT:   cmd.op = OP_SQRT;
            ST_WAITS:  cmd.op = status.sqrt_done ? OP_TAKE_R : OP_NONE;
            ST_PREP3:  cmd.op = OP_PREP3;
            ST_DIV3:   cmd.op = OP_DIV3;
            ST_WAIT3:  cmd.op = status.div_done ? OP_TAKE_S : OP_NONE;
            ST_FINAL:  cmd.op = OP_FINAL;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule
